// File: hw/rtl/asw_pkg.sv
package asw_pkg;

  localparam int POS_FRAC_BITS_DEF    = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int COS_TABLE_DEPTH_DEF  = 1024;

  // round(2^32/pi) and pi in Q2.30
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;

  localparam int SQRT_STEPS     = 32;
  localparam int SQRT_PER_STAGE = 4;
  localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;
  localparam int DIST_STAGES    = 4;
  localparam int PHASE_STAGES   = 6;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_INNER_RADIUS = 3'd3,
    REG_OUTER_RADIUS = 3'd4,
    REG_PHASE_SCALE  = 3'd5,
    REG_GROUP_MASK   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_OUTSIDE = 2'd0,
    CLS_INSIDE  = 2'd1,
    CLS_SHELL   = 2'd2
  } cls_t;

  typedef struct packed {
    logic valid;
    logic match;
    logic last;
    cls_t cls;
  } asw_tag_t;

endpackage

// File: hw/rtl/asw_dist.sv
module asw_dist import asw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic        [31:0] group_bits,
  input  logic               last_atom,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic        [30:0] inner_radius,
  input  logic        [30:0] outer_radius,
  input  logic        [31:0] group_mask,
  output asw_tag_t           tag_o,
  output logic        [63:0] sum_o
);

  logic [2:0]  v_r;
  logic [2:0]  m_r;
  logic [2:0]  l_r;
  logic [32:0] mx_r, my_r, mz_r;
  logic [65:0] sx_r, sy_r, sz_r;
  logic [61:0] ro2_r, ri2_r;
  logic [65:0] sum_r;
  logic [61:0] ro2b_r, ri2b_r;
  asw_tag_t    tag_r;
  logic [63:0] sumo_r;
  logic [32:0] dx_nxt, dy_nxt, dz_nxt;

  always_comb begin
    dx_nxt = {center_x[31], center_x} - {pos_x[31], pos_x};
    dy_nxt = {center_y[31], center_y} - {pos_y[31], pos_y};
    dz_nxt = {center_z[31], center_z} - {pos_z[31], pos_z};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      tag_r.valid <= 1'b0;
    end else begin
      v_r         <= {v_r[1:0], in_valid};
      tag_r.valid <= v_r[2];
    end
    // stage 1: magnitudes of the differences
    m_r[0] <= |(group_bits & group_mask);
    l_r[0] <= last_atom;
    mx_r   <= dx_nxt[32] ? 33'(-dx_nxt) : dx_nxt;
    my_r   <= dy_nxt[32] ? 33'(-dy_nxt) : dy_nxt;
    mz_r   <= dz_nxt[32] ? 33'(-dz_nxt) : dz_nxt;
    // stage 2: squares
    m_r[1] <= m_r[0];
    l_r[1] <= l_r[0];
    sx_r   <= mx_r * mx_r;
    sy_r   <= my_r * my_r;
    sz_r   <= mz_r * mz_r;
    ro2_r  <= outer_radius * outer_radius;
    ri2_r  <= inner_radius * inner_radius;
    // stage 3: exact sum
    m_r[2] <= m_r[1];
    l_r[2] <= l_r[1];
    sum_r  <= sx_r + sy_r + sz_r;
    ro2b_r <= ro2_r;
    ri2b_r <= ri2_r;
    // stage 4: region tests
    tag_r.match <= m_r[2];
    tag_r.last  <= l_r[2];
    if (sum_r > {4'd0, ro2b_r}) begin
      tag_r.cls <= CLS_OUTSIDE;
    end else if (sum_r < {4'd0, ri2b_r}) begin
      tag_r.cls <= CLS_INSIDE;
    end else begin
      tag_r.cls <= CLS_SHELL;
    end
    sumo_r <= sum_r[63:0];
  end

  assign tag_o = tag_r;
  assign sum_o = sumo_r;

endmodule

// File: hw/rtl/asw_sqrt.sv
module asw_sqrt import asw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  asw_tag_t    tag_i,
  input  logic [63:0] val_i,
  output asw_tag_t    tag_o,
  output logic [31:0] root_o
);

  // digit-by-digit integer square root, a few bits per stage
  asw_tag_t    tag_r  [SQRT_STAGES];
  logic [63:0] val_r  [SQRT_STAGES];
  logic [35:0] rem_r  [SQRT_STAGES];
  logic [31:0] root_r [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [63:0] v_in;
    logic [35:0] r_in;
    logic [31:0] q_in;
    asw_tag_t    t_in;
    logic [63:0] v_nxt;
    logic [35:0] r_nxt;
    logic [31:0] q_nxt;
    logic [35:0] trial;

    if (g == 0) begin : g_first
      assign v_in = val_i;
      assign r_in = '0;
      assign q_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign v_in = val_r[g-1];
      assign r_in = rem_r[g-1];
      assign q_in = root_r[g-1];
      assign t_in = tag_r[g-1];
    end

    always_comb begin
      v_nxt = v_in;
      r_nxt = r_in;
      q_nxt = q_in;
      trial = '0;
      for (int s = 0; s < SQRT_PER_STAGE; s++) begin
        r_nxt = {r_nxt[33:0], v_nxt[63:62]};
        v_nxt = {v_nxt[61:0], 2'b00};
        trial = {2'b00, q_nxt, 2'b01};
        if (r_nxt >= trial) begin
          r_nxt = r_nxt - trial;
          q_nxt = {q_nxt[30:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[g].valid <= 1'b0;
      end else begin
        tag_r[g].valid <= t_in.valid;
      end
      tag_r[g].match <= t_in.match;
      tag_r[g].last  <= t_in.last;
      tag_r[g].cls   <= t_in.cls;
      val_r[g]       <= v_nxt;
      rem_r[g]       <= r_nxt;
      root_r[g]      <= q_nxt;
    end
  end

  assign tag_o  = tag_r[SQRT_STAGES-1];
  assign root_o = root_r[SQRT_STAGES-1];

endmodule

// File: hw/rtl/asw_phase.sv
module asw_phase import asw_pkg::*; #(
  parameter int POS_FRAC_BITS    = POS_FRAC_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  parameter int COS_TABLE_DEPTH  = COS_TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  asw_tag_t                    tag_i,
  input  logic [31:0]                 dist_i,
  input  logic [30:0]                 inner_radius,
  input  logic [31:0]                 phase_scale,
  output logic                        strobe_o,
  output logic [WEIGHT_FRAC_BITS:0]   weight_o,
  output logic                        written_o,
  output logic                        last_o
);

  localparam int WW    = WEIGHT_FRAC_BITS + 1;
  localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam int DEP_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam int UPOS  = 32 + POS_FRAC_BITS - 8;
  localparam logic [WW-1:0]    ONE_W     = WW'(1) << WEIGHT_FRAC_BITS;
  localparam logic [DEP_W-1:0] DEPTH_C   = DEP_W'(COS_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_MAX   = IDX_W'(COS_TABLE_DEPTH);

  typedef logic [WW-1:0] rom_t [COS_TABLE_DEPTH+1];

  // shift-subtract quotient, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [WW-1:0] cos2_entry(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] c;
    logic [63:0] r;
    logic [63:0] den;
    x    = udiv64(PI_Q30 * k, 64'(COS_TABLE_DEPTH));
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(64'd1 << 30);
    for (int n = 1; n <= 12; n++) begin
      den  = 64'((2 * n - 1) * (2 * n));
      term = udiv64((term * x2) >> 30, den);
      if ((n & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    c = (sum < 0) ? 64'd0 : 64'(sum);
    if (c > (64'd1 << 30)) begin
      c = 64'd1 << 30;
    end
    r = (c * c + (64'd1 << (59 - WEIGHT_FRAC_BITS))) >> (60 - WEIGHT_FRAC_BITS);
    if (r > 64'(ONE_W)) begin
      r = 64'(ONE_W);
    end
    return WW'(r);
  endfunction

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] m;
    for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
      m    = (2 * k > COS_TABLE_DEPTH) ? 64'(COS_TABLE_DEPTH - k) : 64'(k);
      t[k] = cos2_entry(m);
    end
    return t;
  endfunction

  localparam rom_t COS2_ROM = build_rom();

  asw_tag_t             tag_r [5];
  logic [63:0]          theta_r;
  logic [62:0]          pa_r, pb_r;
  logic [31:0]          u_r;
  logic [IDX_W-1:0]     idx_r;
  logic [WW-1:0]        rom_q_r;
  logic                 strobe_r, written_r, last_r;
  logic [WW-1:0]        weight_r;
  logic [31:0]          dd_nxt;
  logic [95:0]          phase_nxt;
  logic [49:0]          scaled_nxt;
  logic [17:0]          idx_nxt;

  always_comb begin
    dd_nxt     = dist_i - {1'b0, inner_radius};
    phase_nxt  = {1'b0, pa_r, 32'd0} + {33'd0, pb_r};
    scaled_nxt = 50'(u_r) * 50'(DEPTH_C) + (50'd1 << 31);
    idx_nxt    = 18'(scaled_nxt >> 32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        tag_r[i].valid <= 1'b0;
      end
      strobe_r <= 1'b0;
    end else begin
      tag_r[0].valid <= tag_i.valid;
      for (int i = 1; i < 5; i++) begin
        tag_r[i].valid <= tag_r[i-1].valid;
      end
      strobe_r <= tag_r[4].valid;
    end
    tag_r[0].match <= tag_i.match;
    tag_r[0].last  <= tag_i.last;
    tag_r[0].cls   <= tag_i.cls;
    for (int i = 1; i < 5; i++) begin
      tag_r[i].match <= tag_r[i-1].match;
      tag_r[i].last  <= tag_r[i-1].last;
      tag_r[i].cls   <= tag_r[i-1].cls;
    end
    theta_r <= phase_scale * dd_nxt;
    pa_r    <= theta_r[63:32] * INV_PI_Q32;
    pb_r    <= theta_r[31:0] * INV_PI_Q32;
    u_r     <= phase_nxt[UPOS +: 32];
    idx_r   <= (idx_nxt > 18'(IDX_MAX)) ? IDX_MAX : IDX_W'(idx_nxt);
    rom_q_r <= COS2_ROM[idx_r];
    written_r <= tag_r[4].match;
    last_r    <= tag_r[4].last;
    if (!tag_r[4].match) begin
      weight_r <= '0;
    end else begin
      case (tag_r[4].cls)
        CLS_INSIDE:  weight_r <= ONE_W;
        CLS_SHELL:   weight_r <= rom_q_r;
        default:     weight_r <= '0;
      endcase
    end
  end

  assign strobe_o  = strobe_r;
  assign weight_o  = weight_r;
  assign written_o = written_r;
  assign last_o    = last_r;

endmodule

// File: hw/rtl/adress_sphere_weight.sv
// Spherical hybrid-region weight. One atom word enters per clock whenever
// start is high; busy is never raised. Each atom yields exactly one result
// word, shown for one cycle with out_strobe, after it passes 4 distance
// stages, 8 square-root stages at 4 root bits each and 6 phase and cos^2
// table stages. The receiver cannot stall the pipe. The user must write
// registers through cfg_* only at a time the pipe is empty; the block does
// not enforce this. cfg_ready is always high.
module adress_sphere_weight import asw_pkg::*; #(
  parameter int POS_FRAC_BITS    = POS_FRAC_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  parameter int COS_TABLE_DEPTH  = COS_TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [31:0]        in_pos_x,
  input  logic signed [31:0]        in_pos_y,
  input  logic signed [31:0]        in_pos_z,
  input  logic        [31:0]        in_group_bits,
  input  logic                      in_last_atom,
  output logic                      out_strobe,
  output logic [WEIGHT_FRAC_BITS:0] out_weight,
  output logic                      out_written,
  output logic                      out_last_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data
);

  localparam int LATENCY = DIST_STAGES + SQRT_STAGES + PHASE_STAGES;

  logic signed [31:0] center_x_r, center_y_r, center_z_r;
  logic [30:0]        inner_radius_r, outer_radius_r;
  logic [31:0]        phase_scale_r, group_mask_r;
  asw_tag_t           dist_tag, sqrt_tag;
  logic [63:0]        dist_sum;
  logic [31:0]        root;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      center_z_r     <= '0;
      inner_radius_r <= '0;
      outer_radius_r <= '0;
      phase_scale_r  <= '0;
      group_mask_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_CENTER_X:     center_x_r     <= cfg_data;
        REG_CENTER_Y:     center_y_r     <= cfg_data;
        REG_CENTER_Z:     center_z_r     <= cfg_data;
        REG_INNER_RADIUS: inner_radius_r <= cfg_data[30:0];
        REG_OUTER_RADIUS: outer_radius_r <= cfg_data[30:0];
        REG_PHASE_SCALE:  phase_scale_r  <= cfg_data;
        REG_GROUP_MASK:   group_mask_r   <= cfg_data;
        default:          ;
      endcase
    end
  end

  asw_dist u_dist (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .pos_z        (in_pos_z),
    .group_bits   (in_group_bits),
    .last_atom    (in_last_atom),
    .center_x     (center_x_r),
    .center_y     (center_y_r),
    .center_z     (center_z_r),
    .inner_radius (inner_radius_r),
    .outer_radius (outer_radius_r),
    .group_mask   (group_mask_r),
    .tag_o        (dist_tag),
    .sum_o        (dist_sum)
  );

  asw_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (dist_tag),
    .val_i  (dist_sum),
    .tag_o  (sqrt_tag),
    .root_o (root)
  );

  asw_phase #(
    .POS_FRAC_BITS    (POS_FRAC_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .COS_TABLE_DEPTH  (COS_TABLE_DEPTH)
  ) u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .tag_i        (sqrt_tag),
    .dist_i       (root),
    .inner_radius (inner_radius_r),
    .phase_scale  (phase_scale_r),
    .strobe_o     (out_strobe),
    .weight_o     (out_weight),
    .written_o    (out_written),
    .last_o       (out_last_out)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_strobe)
    else $error("accepted word did not come out on time");
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LATENCY))
    else $error("result word without an accepted atom");
  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_written) |-> (out_weight == '0))
    else $error("unselected atom got a nonzero weight");
  a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_weight <= ((WEIGHT_FRAC_BITS+1)'(1) << WEIGHT_FRAC_BITS)))
    else $error("weight above one");
`endif

endmodule

// File: dv/adress_sphere_weight_test.sv
module adress_sphere_weight_test;
  import asw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_SPARE = 3'd7;  // no register behind this index
  localparam int TABLE_DEPTH = 1024;
  localparam longint unsigned ONE_WEIGHT = 64'd65536;
  localparam longint unsigned PI_Q30_C = 64'd3373259426;
  localparam longint unsigned INV_PI_C = 64'd1367130551;
  localparam longint unsigned HALF_PI_Q24 = 64'd26353589;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [16:0] weight;
    bit          written;
    bit          last;
  } weight_word_t;

  class weight_board;
    longint          cx, cy, cz;
    longint unsigned r_inner, r_outer, phase, mask;
    logic [16:0]     cos2_rom [0:TABLE_DEPTH];
    weight_word_t    pending[$];
    int              errors;
    int              checked;
    int              shell_hits;

    function new();
      longint unsigned x, x2, term, c, r, m;
      longint          acc;
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
        m = (2 * k > TABLE_DEPTH) ? TABLE_DEPTH - k : k;
        x = PI_Q30_C * m / TABLE_DEPTH;
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        acc = longint'(term);
        for (int n = 1; n <= 12; n++) begin
          term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
          if (n % 2 == 1) acc -= longint'(term);
          else acc += longint'(term);
        end
        c = (acc < 0) ? 0 : longint'(acc);
        if (c > (64'd1 << 30)) c = 64'd1 << 30;
        r = (c * c + (64'd1 << 43)) >> 44;
        cos2_rom[k] = (r > ONE_WEIGHT) ? ONE_WEIGHT[16:0] : r[16:0];
      end
      errors = 0;
      checked = 0;
      shell_hits = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_CENTER_X:     cx = longint'(signed'(v));
        REG_CENTER_Y:     cy = longint'(signed'(v));
        REG_CENTER_Z:     cz = longint'(signed'(v));
        REG_INNER_RADIUS: r_inner = v[30:0];
        REG_OUTER_RADIUS: r_outer = v[30:0];
        REG_PHASE_SCALE:  phase = v;
        REG_GROUP_MASK:   mask = v;
        default: ;
      endcase
    endfunction

    static function longint unsigned axis_sq(longint ctr, logic [31:0] p);
      longint d;
      d = ctr - longint'(signed'(p));
      if (d < 0) d = -d;
      return longint'(d) * longint'(d);
    endfunction

    static function longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_atom(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] grp, bit last);
      weight_word_t    w;
      logic [65:0]     dist2;
      longint unsigned d, theta, pa, pb, u, idx;
      w.weight = 0;
      w.written = 0;
      w.last = last;
      if ((grp & mask[31:0]) != 0) begin
        w.written = 1;
        dist2 = 66'(axis_sq(cx, px)) + 66'(axis_sq(cy, py)) + 66'(axis_sq(cz, pz));
        if (dist2 > 66'(r_outer * r_outer)) begin
          w.weight = 0;
        end else if (dist2 < 66'(r_inner * r_inner)) begin
          w.weight = ONE_WEIGHT[16:0];
        end else begin
          shell_hits++;
          d = int_root(dist2[63:0]);
          theta = phase * (d - r_inner);
          pa = (theta >> 32) * INV_PI_C;
          pb = (theta & 64'hFFFF_FFFF) * INV_PI_C;
          u = ((pa + (pb >> 32)) >> 8) & 64'hFFFF_FFFF;
          idx = (u * TABLE_DEPTH + 64'h8000_0000) >> 32;
          if (idx > TABLE_DEPTH) idx = TABLE_DEPTH;
          w.weight = cos2_rom[idx];
        end
      end
      pending.push_back(w);
    endfunction

    function void report(string what);
      errors++;
      $display("[%0t] MISMATCH %s", $realtime, what);
    endfunction

    function void check_result(logic [16:0] wt, logic wr, logic lst);
      weight_word_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word weight=%0d written=%0b", wt, wr));
        return;
      end
      e = pending.pop_front();
      checked++;
      if (wt !== e.weight) report($sformatf("weight got %0d want %0d", wt, e.weight));
      if (wr !== e.written) report($sformatf("written got %0b want %0b", wr, e.written));
      if (lst !== e.last) report($sformatf("last_out got %0b want %0b", lst, e.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_pos_x, in_pos_y, in_pos_z, in_group_bits;
  logic        in_last_atom;
  logic        out_strobe;
  logic [16:0] out_weight;
  logic        out_written, out_last_out;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  weight_board board;
  int          burst_left;
  int          cycles;
  int          sent;

  adress_sphere_weight u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_group_bits(in_group_bits),
    .in_last_atom (in_last_atom),
    .out_strobe   (out_strobe),
    .out_weight   (out_weight),
    .out_written  (out_written),
    .out_last_out (out_last_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_result(out_weight, out_written, out_last_out);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("adress_sphere_weight_test: errors");
      $finish;
    end
  end

  task automatic send_atom(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] grp, bit last);
    logic was_busy;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_group_bits <= grp;
    in_last_atom <= last;
    start <= 1'b1;
    forever begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
    end
    board.note_atom(px, py, pz, grp, last);
    sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  // drop start, let the pipe empty before touching registers
  task automatic drain();
    if (start) start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    logic rdy;
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    forever begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
      if (rdy) break;
    end
    cfg_valid <= 1'b0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic load_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] rin, logic [31:0] rout,
                             logic [31:0] ps, logic [31:0] msk);
    drain();
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_CENTER_Z, z);
    write_reg(REG_INNER_RADIUS, rin);
    write_reg(REG_OUTER_RADIUS, rout);
    write_reg(REG_PHASE_SCALE, ps);
    write_reg(REG_GROUP_MASK, msk);
  endtask

  function automatic logic [31:0] matched_phase(longint unsigned rin, longint unsigned rout);
    longint unsigned w, p;
    if (rout <= rin) return $urandom;
    w = rout - rin;
    p = (HALF_PI_Q24 * 65536) / w;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  // one atom near the sphere, or pure noise now and then
  task automatic random_atom();
    longint unsigned span;
    logic [31:0]     grp, off[3];
    logic [31:0]     lowbit;
    lowbit = board.mask[31:0] & (~board.mask[31:0] + 32'd1);
    span = board.r_outer + board.r_outer / 4 + 16;
    if (span > 64'h3FFF_FFFF) span = 64'h3FFF_FFFF;
    for (int a = 0; a < 3; a++) begin
      off[a] = 32'(longint'($urandom_range(0, 32'(2 * span))) - longint'(span));
      if ($urandom_range(0, 3) == 0) off[a] = off[a] >>> $urandom_range(1, 12);
    end
    grp = ($urandom_range(0, 9) < 8) ? ($urandom | lowbit) : ($urandom & ~board.mask[31:0]);
    if ($urandom_range(0, 9) == 0)
      send_atom($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    else
      send_atom(32'(board.cx) + off[0], 32'(board.cy) + off[1], 32'(board.cz) + off[2],
                grp, $urandom_range(0, 7) == 0);
  endtask

  initial begin
    longint unsigned rin, rout;
    logic [31:0]     msk;
    board = new();
    board.set_reg(REG_CENTER_X, 0);
    board.set_reg(REG_CENTER_Y, 0);
    board.set_reg(REG_CENTER_Z, 0);
    board.set_reg(REG_INNER_RADIUS, 0);
    board.set_reg(REG_OUTER_RADIUS, 0);
    board.set_reg(REG_PHASE_SCALE, 0);
    board.set_reg(REG_GROUP_MASK, 0);
    cycles = 0;
    sent = 0;
    burst_left = 4;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_pos_z <= '0;
    in_group_bits <= '0;
    in_last_atom <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: mask is zero, nothing gets written
    send_atom(0, 0, 0, 32'hFFFF_FFFF, 1);
    send_atom(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h1, 0);

    // shell 10..20 units around the origin
    load_sphere(0, 0, 0, 32'd10 << 16, 32'd20 << 16,
                matched_phase(64'd10 << 16, 64'd20 << 16), 32'h0000_0001);
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    send_atom(0, 0, 0, 32'h1, 0);                           // at centre
    send_atom(32'd10 << 16, 0, 0, 32'h1, 0);                // on inner edge
    send_atom(32'd15 << 16, 0, 0, 32'h1, 1);                // mid shell
    send_atom(0, 32'd20 << 16, 0, 32'h1, 0);                // on outer edge
    send_atom(0, 0, (32'd20 << 16) + 1, 32'h1, 0);          // just beyond
    send_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1);
    send_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 0);
    send_atom(32'd12 << 16, 32'd5 << 16, 0, 32'hFFFF_FFFE, 0); // group miss

    // extremes of every register but center z
    load_sphere(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_atom(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0000_0001, 0);
    send_atom(32'hFFFF_0000, 32'h7FFF_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_atom(32'h0000_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h5555_5555, 1);

    // inner above outer: no shell
    load_sphere(32'h0001_0000, 32'hFFFF_0000, 0, 32'd30 << 16, 32'd8 << 16,
                32'h0100_0000, 32'h8000_0000);
    send_atom(32'h0001_0000, 32'hFFFF_0000, 0, 32'h8000_0000, 0);
    send_atom(32'd9 << 16, 0, 0, 32'h8000_0000, 0);
    send_atom(32'd8 << 16, 32'hFFFF_0000, 0, 32'hC000_0000, 1);

    // phase scale far too large: cos^2 wraps
    load_sphere(0, 0, 0, 32'd1 << 16, 32'd400 << 16, 32'h7FFF_FFFF, 32'h0000_00F0);
    for (int i = 0; i < 6; i++) send_atom(32'(i * 70) << 16, 32'd3 << 16, 0, 32'h10, 0);

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: rin = $urandom_range(0, 32'h0010_0000);
        1: rin = $urandom_range(0, 32'h0400_0000);
        2: rin = $urandom_range(0, 32'h7FFF_FFFF);
        default: rin = 0;
      endcase
      rout = rin + $urandom_range(1, 32'h0080_0000);
      if (rout > 64'h7FFF_FFFF) rout = 64'h7FFF_FFFF;
      if (ph == 3) rout = rin / 2;
      msk = (ph == 5) ? 32'hFFFF_FFFF : ($urandom | (32'h1 << $urandom_range(0, 31)));
      load_sphere($urandom, $urandom, $urandom, rin[31:0], rout[31:0],
                  ($urandom_range(0, 3) == 0) ? $urandom : matched_phase(rin, rout), msk);
      for (int i = 0; i < 210; i++) random_atom();
    end

    drain();
    $display("sent %0d atom words, checked %0d results, %0d landed in the shell",
             sent, board.checked, board.shell_hits);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("adress_sphere_weight_test: clean");
    end else begin
      $display("adress_sphere_weight_test: errors");
    end
    $finish;
  end

endmodule
